// ----- rtl/assert_macros.svh -----
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant failed");

`endif

// ----- rtl/scsa_pkg.sv -----
`timescale 1ns / 1ps

package scsa_pkg;

	localparam int SLOTS_PER_CLASS = 64;
	localparam int NUM_CLASSES     = 6;
	localparam int MAX_SLOT_BYTES  = 128;
	localparam int MIN_SHIFT       = 2;

	localparam int TYPE_W   = 2;
	localparam int SIZE_W   = 8;
	localparam int ADDR_W   = 16;
	localparam int STATUS_W = 3;
	localparam int BYTES_W  = 8;
	localparam int CLS_W    = 3;

	localparam int SLOT_W       = $clog2(SLOTS_PER_CLASS);
	localparam int CNT_W        = $clog2(SLOTS_PER_CLASS + 1);
	localparam int REGION_SHIFT = $clog2(SLOTS_PER_CLASS * MAX_SLOT_BYTES);
	localparam int OFF_W        = REGION_SHIFT;
	localparam int TOTAL_SLOTS  = NUM_CLASSES * SLOTS_PER_CLASS;
	localparam int RAM_AW       = $clog2(TOTAL_SLOTS);
	localparam int CIDX_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

	typedef enum logic [TYPE_W-1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_BAD   = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_EXHAUSTED   = 3'd1,
		ST_BAD_SIZE    = 3'd2,
		ST_NOT_OWNED   = 3'd3,
		ST_DOUBLE_FREE = 3'd4
	} status_t;

	typedef struct packed {
		logic              alloc_ok;
		logic [CLS_W-1:0]  alloc_cls;
		logic              loc_ok;
		logic              loc_align;
		logic [CLS_W-1:0]  loc_cls;
		logic [SLOT_W-1:0] slot;
	} dec_t;

	function automatic logic class_usable(logic [CLS_W-1:0] c);
		return (32'(c) < 32'(NUM_CLASSES)) && ((32'd4 << c) <= 32'(MAX_SLOT_BYTES));
	endfunction

	// ceiling log2 of the size in units of the smallest slot
	function automatic logic [CLS_W-1:0] size_to_class(logic [SIZE_W-1:0] size);
		logic [CLS_W-1:0] c;
		c = '0;
		for (int i = 0; i < (2 ** CLS_W) - 1; i++) begin
			if ((32'd4 << i) < 32'(size))
				c = c + 1'b1;
		end
		return c;
	endfunction

	function automatic logic [BYTES_W-1:0] class_bytes(logic [CLS_W-1:0] c);
		return BYTES_W'(32'd4 << c);
	endfunction

	function automatic logic [RAM_AW-1:0] ram_index(logic [CLS_W-1:0] c, logic [SLOT_W-1:0] s);
		return RAM_AW'(32'(c) * SLOTS_PER_CLASS + 32'(s));
	endfunction

endpackage

// ----- rtl/scsa_ram.sv -----
`timescale 1ns / 1ps

module scsa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- rtl/scsa_req_decode.sv -----
`timescale 1ns / 1ps

module scsa_req_decode (
	input  logic [scsa_pkg::SIZE_W-1:0] req_size,
	input  logic [scsa_pkg::ADDR_W-1:0] address,
	output scsa_pkg::dec_t              dec
);

	import scsa_pkg::*;

	logic [CLS_W-1:0]  acls;
	logic [ADDR_W-1:0] region;
	logic [CLS_W-1:0]  lcls;
	logic [OFF_W-1:0]  off;
	logic [OFF_W-1:0]  slot_full;
	logic [OFF_W-1:0]  low_mask;

	always_comb begin
		acls          = size_to_class(req_size);
		dec.alloc_cls = acls;
		dec.alloc_ok  = (req_size != '0) && (32'(req_size) <= 32'(MAX_SLOT_BYTES))
			&& class_usable(acls);

		// owning region, then slot index and alignment within it
		region    = address >> REGION_SHIFT;
		lcls      = CLS_W'(region);
		off       = address[OFF_W-1:0];
		slot_full = off >> (32'(lcls) + MIN_SHIFT);
		low_mask  = (OFF_W'(1) << (32'(lcls) + MIN_SHIFT)) - OFF_W'(1);

		dec.loc_cls   = lcls;
		dec.loc_ok    = (32'(region) < 32'(NUM_CLASSES)) && class_usable(lcls)
			&& (32'(slot_full) < 32'(SLOTS_PER_CLASS));
		dec.loc_align = (off & low_mask) == '0;
		dec.slot      = SLOT_W'(slot_full);
	end

endmodule

// ----- rtl/size_class_slab_allocator_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Slab allocator with six size classes of 4 to 128 byte slots, 64 slots each, every class in
// its own 8 KiB region and served from a LIFO free list. Requests are allocate, free and
// size query; one result word comes back for every request word, in order. One request is
// taken per clock unless a held result stalls the input. Each request passes the input decode
// with the memory read, then the result register. Back-to-back requests to the same class are
// resolved by forwarding the per-class stack pointer and the memory write data. Free-list
// entries and ownership bits live in two 384-entry memories. Slots never handed out since
// reset are tracked by a per-class fresh counter, so the block is ready right after reset with
// no clearing pass. Freshly reset classes hand out slots in ascending address order.
module size_class_slab_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [scsa_pkg::TYPE_W-1:0]   req_type,
	input  logic [scsa_pkg::SIZE_W-1:0]   req_size,
	input  logic [scsa_pkg::ADDR_W-1:0]   address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [scsa_pkg::STATUS_W-1:0] status,
	output logic [scsa_pkg::ADDR_W-1:0]   slot_address,
	output logic [scsa_pkg::BYTES_W-1:0]  slot_bytes,
	output logic [scsa_pkg::CLS_W-1:0]    size_class
);

	import scsa_pkg::*;

	logic [CNT_W-1:0] top_q   [NUM_CLASSES];
	logic [CNT_W-1:0] fresh_q [NUM_CLASSES];
	logic [CNT_W-1:0] top_d   [NUM_CLASSES];
	logic [CNT_W-1:0] fresh_d [NUM_CLASSES];

	logic              valid_s1;
	req_t              type_s1;
	logic [ADDR_W-1:0] address_s1;
	dec_t              dec_s1;
	logic              stk_byp_s1;
	logic [SLOT_W-1:0] stk_bdata_s1;
	logic              use_byp_s1;
	logic              use_bdata_s1;

	dec_t dec_in;
	logic out_ready;
	logic adv;
	logic acc;

	logic [CLS_W-1:0]  acc_cls;
	logic [CIDX_W-1:0] acc_cidx;
	logic [CIDX_W-1:0] cidx;
	logic [CNT_W-1:0]  top_c;
	logic [CNT_W-1:0]  fresh_c;
	logic              fresh_pop;
	logic [SLOT_W-1:0] stk_data;
	logic [SLOT_W-1:0] pop_slot;
	logic              use_data;
	logic              in_use;

	logic             upd;
	logic [CNT_W-1:0] upd_top;
	logic [CNT_W-1:0] upd_fresh;

	logic              stk_we;
	logic [RAM_AW-1:0] stk_waddr;
	logic [SLOT_W-1:0] stk_wdata;
	logic [RAM_AW-1:0] stk_raddr;
	logic [SLOT_W-1:0] stk_rdata;
	logic              use_we;
	logic [RAM_AW-1:0] use_waddr;
	logic              use_wdata;
	logic [RAM_AW-1:0] use_raddr;
	logic              use_rdata;

	status_t            res_status;
	logic [ADDR_W-1:0]  res_addr;
	logic [BYTES_W-1:0] res_bytes;
	logic [CLS_W-1:0]   res_cls;

	logic               out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]  slot_address_q;
	logic [BYTES_W-1:0] slot_bytes_q;
	logic [CLS_W-1:0]   size_class_q;

	scsa_req_decode u_decode (
		.req_size (req_size),
		.address  (address),
		.dec      (dec_in)
	);

	scsa_ram #(.WIDTH(SLOT_W), .DEPTH(TOTAL_SLOTS)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (acc),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	scsa_ram #(.WIDTH(1), .DEPTH(TOTAL_SLOTS)) u_use_ram (
		.clk   (clk),
		.we    (use_we),
		.waddr (use_waddr),
		.wdata (use_wdata),
		.re    (acc),
		.raddr (use_raddr),
		.rdata (use_rdata)
	);

	assign out_ready = !out_valid_q || !out_stall;
	assign adv       = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign acc       = in_valid && !in_stall;

	// read addresses for the incoming word, using the pointer after the word in flight
	always_comb begin
		acc_cls   = dec_in.alloc_ok ? dec_in.alloc_cls : '0;
		acc_cidx  = CIDX_W'(acc_cls);
		stk_raddr = ram_index(acc_cls, SLOT_W'(top_d[acc_cidx] - 1'b1));
		use_raddr = ram_index(dec_in.loc_ok ? dec_in.loc_cls : '0, dec_in.slot);
	end

	always_comb begin
		cidx = '0;
		if (type_s1 == REQ_ALLOC && dec_s1.alloc_ok)
			cidx = CIDX_W'(dec_s1.alloc_cls);
		else if (type_s1 == REQ_FREE && dec_s1.loc_ok)
			cidx = CIDX_W'(dec_s1.loc_cls);
	end

	always_comb begin
		top_c     = top_q[cidx];
		fresh_c   = fresh_q[cidx];
		// stack depth equal to the fresh count: next slot comes from the untouched range
		fresh_pop = top_c == fresh_c;
		stk_data  = stk_byp_s1 ? stk_bdata_s1 : stk_rdata;
		pop_slot  = fresh_pop ? SLOT_W'(CNT_W'(SLOTS_PER_CLASS) - top_c) : stk_data;
		use_data  = use_byp_s1 ? use_bdata_s1 : use_rdata;
		in_use    = use_data && (CNT_W'(dec_s1.slot) < (CNT_W'(SLOTS_PER_CLASS) - fresh_c));

		res_status = ST_OK;
		res_addr   = '0;
		res_bytes  = '0;
		res_cls    = '0;
		upd        = 1'b0;
		upd_top    = top_c;
		upd_fresh  = fresh_c;
		stk_we     = 1'b0;
		stk_waddr  = ram_index(dec_s1.loc_cls, top_c[SLOT_W-1:0]);
		stk_wdata  = dec_s1.slot;
		use_we     = 1'b0;
		use_waddr  = ram_index(dec_s1.loc_cls, dec_s1.slot);
		use_wdata  = 1'b0;

		unique case (type_s1)
			REQ_ALLOC: begin
				if (!dec_s1.alloc_ok) begin
					res_status = ST_BAD_SIZE;
				end else begin
					res_bytes = class_bytes(dec_s1.alloc_cls);
					res_cls   = dec_s1.alloc_cls;
					if (top_c == '0) begin
						res_status = ST_EXHAUSTED;
					end else begin
						res_addr = ADDR_W'((32'(dec_s1.alloc_cls) << REGION_SHIFT)
							+ (32'(pop_slot) << (32'(dec_s1.alloc_cls) + MIN_SHIFT)));
						upd     = adv;
						upd_top = top_c - 1'b1;
						if (fresh_pop)
							upd_fresh = fresh_c - 1'b1;
						use_we    = adv;
						use_waddr = ram_index(dec_s1.alloc_cls, pop_slot);
						use_wdata = 1'b1;
					end
				end
			end
			REQ_FREE: begin
				res_addr = address_s1;
				if (!(dec_s1.loc_ok && dec_s1.loc_align)) begin
					res_status = ST_NOT_OWNED;
				end else begin
					res_bytes = class_bytes(dec_s1.loc_cls);
					res_cls   = dec_s1.loc_cls;
					if (!in_use) begin
						res_status = ST_DOUBLE_FREE;
					end else begin
						use_we = adv;
						if (top_c < CNT_W'(SLOTS_PER_CLASS)) begin
							stk_we  = adv;
							upd     = adv;
							upd_top = top_c + 1'b1;
						end
					end
				end
			end
			REQ_QUERY: begin
				res_addr = address_s1;
				if (dec_s1.loc_ok) begin
					res_bytes = class_bytes(dec_s1.loc_cls);
					res_cls   = dec_s1.loc_cls;
				end
			end
			REQ_BAD: begin
				res_status = ST_BAD_SIZE;
			end
			default: begin
				res_status = ST_BAD_SIZE;
			end
		endcase
	end

	always_comb begin
		top_d   = top_q;
		fresh_d = fresh_q;
		if (upd) begin
			top_d[cidx]   = upd_top;
			fresh_d[cidx] = upd_fresh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				top_q[c]   <= CNT_W'(SLOTS_PER_CLASS);
				fresh_q[c] <= CNT_W'(SLOTS_PER_CLASS);
			end
		end else begin
			top_q   <= top_d;
			fresh_q <= fresh_d;
			if (acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			out_valid_q <= adv || (out_valid_q && out_stall);
		end
	end

	// word registers; bypass covers a read and a write to one entry at the same edge
	always_ff @(posedge clk) begin
		if (acc) begin
			type_s1      <= req_t'(req_type);
			address_s1   <= address;
			dec_s1       <= dec_in;
			stk_byp_s1   <= stk_we && (stk_waddr == stk_raddr);
			stk_bdata_s1 <= stk_wdata;
			use_byp_s1   <= use_we && (use_waddr == use_raddr);
			use_bdata_s1 <= use_wdata;
		end
		if (adv) begin
			status_q       <= res_status;
			slot_address_q <= res_addr;
			slot_bytes_q   <= res_bytes;
			size_class_q   <= res_cls;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot_address = slot_address_q;
	assign slot_bytes   = slot_bytes_q;
	assign size_class   = size_class_q;

	`ASSERT_IMP(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall)
	`ASSERT_NEXT(a_adv_shows, adv, out_valid)
	`ASSERT_IMP(a_pop_nonempty, upd && type_s1 == REQ_ALLOC, top_c != '0)
	`ASSERT_IMP(a_push_room, stk_we, top_c < CNT_W'(SLOTS_PER_CLASS))

	for (genvar gi = 0; gi < NUM_CLASSES; gi++) begin : g_chk
		`ASSERT_ALWAYS(a_fresh_le_top, fresh_q[gi] <= top_q[gi])
	end

endmodule
